### hw/rtl/alp_pkg.sv
// Shared definitions for the array list core: field widths, request and
// status codes, and the control bundle for the address unit.
// No dependencies; alp_addr_unit and the core top level use it by scoped names.
package alp_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int VALUE_BITS_DEF = 32;

	localparam int REQ_W    = 3;
	localparam int POS_W    = 4;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	localparam logic [REQ_W-1:0] REQ_APPEND    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_INS_AT    = 3'd1;
	localparam logic [REQ_W-1:0] REQ_INS_AFTER = 3'd2;
	localparam logic [REQ_W-1:0] REQ_REMOVE    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_READ      = 3'd4;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOPOS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic load;
		logic step;
		logic down;
	} addr_ctl_t;

endpackage

### hw/rtl/alp_mem.sv
// Element storage: one write port and one read port with registered read data.
// Depends on nothing but its parameters.
module alp_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/alp_addr_unit.sv
// Shared address unit: a pointer register with one increment/decrement adder
// and one compare against a limit register. Uses alp_pkg::addr_ctl_t.
module alp_addr_unit #(
	parameter int CW = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  alp_pkg::addr_ctl_t ctl,
	input  logic [CW-1:0]      load_ptr,
	input  logic [CW-1:0]      load_lim,
	output logic [CW-1:0]      ptr,
	output logic [CW-1:0]      next,
	output logic               at_lim
);

	logic [CW-1:0] ptr_q;
	logic [CW-1:0] lim_q;

	assign next   = ptr_q + (ctl.down ? {CW{1'b1}} : CW'(1));
	assign at_lim = (ptr_q == lim_q);
	assign ptr    = ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			lim_q <= '0;
		end else if (ctl.load) begin
			ptr_q <= load_ptr;
			lim_q <= load_lim;
		end else if (ctl.step) begin
			ptr_q <= next;
		end
	end

endmodule

### hw/rtl/array_list_positional_insert_remove_core.sv
// Top level of the bounded array list: request decode, sequencer, result register.
// Depends on alp_pkg, alp_mem and alp_addr_unit.
//
//   channel | valid     | ready     | payload
//   input   | in_valid  | in_ready  | req_type, position, value
//   result  | out_valid | out_ready | status, read_value, element_count
//
// One item is worked on at a time; in_ready is high only while the sequencer is idle.
// A rejected or unused request goes straight to the finish step; an append or insert moves
// the elements from the insert point up by one, last first, then writes the new value; a
// read fetches the element; a remove fetches it, then moves the later elements down by one.
// Each moved element takes its own write on the memory port, so the longest request is a
// remove at position 0 of a full list.
// The result register holds a finished item; the next item is accepted meanwhile and
// its result waits in the sequencer until the register is free.
// Reset clears the count (empty list); stored elements are not cleared.
module array_list_positional_insert_remove_core #(
	parameter int CAPACITY   = alp_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = alp_pkg::VALUE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic        [alp_pkg::REQ_W-1:0]    req_type,
	input  logic        [alp_pkg::POS_W-1:0]    position,
	input  logic signed [alp_pkg::DATA_W-1:0]   value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic        [alp_pkg::STATUS_W-1:0] status,
	output logic signed [alp_pkg::DATA_W-1:0]   read_value,
	output logic        [alp_pkg::COUNT_W-1:0]  element_count
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int AW   = $clog2(CAPACITY);
	localparam int CMPW = (CW > alp_pkg::POS_W) ? CW : alp_pkg::POS_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_OPEN,
		S_RD,
		S_RD2,
		S_CLOSE,
		S_FINISH
	} state_t;

	state_t                          state_q;
	logic [CW-1:0]                   count_q;
	logic                            rm_q;
	logic [VALUE_BITS-1:0]           val_q;
	logic [VALUE_BITS-1:0]           rd_q;
	logic [alp_pkg::STATUS_W-1:0]    st_q;
	logic                            pend_s1;
	logic [AW-1:0]                   wa_s1;
	logic                            out_valid_q;
	logic [alp_pkg::STATUS_W-1:0]    out_st_q;
	logic [alp_pkg::DATA_W-1:0]      out_rd_q;
	logic [CW-1:0]                   out_cnt_q;

	alp_pkg::addr_ctl_t              actl;
	logic [CW-1:0]                   load_ptr;
	logic [CW-1:0]                   load_lim;
	logic [CW-1:0]                   ptr;
	logic [CW-1:0]                   next;
	logic                            at_lim;

	logic                            mem_we;
	logic [AW-1:0]                   mem_waddr;
	logic [VALUE_BITS-1:0]           mem_wdata;
	logic [AW-1:0]                   mem_raddr;
	logic [VALUE_BITS-1:0]           mem_rdata;

	logic [CMPW-1:0]                 pos_c;
	logic [CMPW-1:0]                 cnt_c;
	logic                            pos_ok;
	logic                            full;
	logic                            accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	assign pos_c  = CMPW'(position);
	assign cnt_c  = CMPW'(count_q);
	assign pos_ok = (pos_c < cnt_c);
	assign full   = (count_q == CW'(CAPACITY));

	// Start values for the address unit. Inserts walk down from the count to the
	// insert point; remove and read start at the position, and a remove walks up to the last element.
	always_comb begin
		load_ptr = count_q;
		load_lim = count_q;
		case (req_type)
			alp_pkg::REQ_INS_AT: begin
				load_lim = CW'(pos_c);
			end
			alp_pkg::REQ_INS_AFTER: begin
				load_lim = CW'(pos_c + CMPW'(1));
			end
			alp_pkg::REQ_REMOVE, alp_pkg::REQ_READ: begin
				load_ptr = CW'(pos_c);
				load_lim = count_q - CW'(1);
			end
			default: begin
				load_ptr = count_q;
				load_lim = count_q;
			end
		endcase
	end

	always_comb begin
		actl.load = accept;
		actl.step = ((state_q == S_OPEN) || (state_q == S_CLOSE)) && !at_lim;
		actl.down = (state_q == S_OPEN);
	end

	alp_addr_unit #(
		.CW(CW)
	) u_addr (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (actl),
		.load_ptr (load_ptr),
		.load_lim (load_lim),
		.ptr      (ptr),
		.next     (next),
		.at_lim   (at_lim)
	);

	// A pending move writes the element read in the previous cycle; the new value
	// goes in at the insert point once all moves have landed.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wa_s1;
		mem_wdata = mem_rdata;
		mem_raddr = (state_q == S_RD) ? ptr[AW-1:0] : next[AW-1:0];
		if ((state_q == S_OPEN) || (state_q == S_CLOSE)) begin
			if (pend_s1) begin
				mem_we = 1'b1;
			end else if ((state_q == S_OPEN) && at_lim) begin
				mem_we    = 1'b1;
				mem_waddr = ptr[AW-1:0];
				mem_wdata = val_q;
			end
		end
	end

	alp_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (VALUE_BITS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rm_q        <= 1'b0;
			val_q       <= '0;
			rd_q        <= '0;
			st_q        <= alp_pkg::ST_DONE;
			pend_s1     <= 1'b0;
			wa_s1       <= '0;
			out_valid_q <= 1'b0;
			out_st_q    <= alp_pkg::ST_DONE;
			out_rd_q    <= '0;
			out_cnt_q   <= '0;
		end else begin
			// The finish step refills the register itself when it hands over a result.
			if (out_valid_q && out_ready && (state_q != S_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						rm_q    <= (req_type == alp_pkg::REQ_REMOVE);
						val_q   <= VALUE_BITS'(value);
						rd_q    <= '0;
						pend_s1 <= 1'b0;
						case (req_type)
							alp_pkg::REQ_APPEND: begin
								if (full) begin
									st_q    <= alp_pkg::ST_FULL;
									state_q <= S_FINISH;
								end else begin
									st_q    <= alp_pkg::ST_DONE;
									state_q <= S_OPEN;
								end
							end
							alp_pkg::REQ_INS_AT, alp_pkg::REQ_INS_AFTER: begin
								if (!pos_ok) begin
									st_q    <= alp_pkg::ST_NOPOS;
									state_q <= S_FINISH;
								end else if (full) begin
									st_q    <= alp_pkg::ST_FULL;
									state_q <= S_FINISH;
								end else begin
									st_q    <= alp_pkg::ST_DONE;
									state_q <= S_OPEN;
								end
							end
							alp_pkg::REQ_REMOVE, alp_pkg::REQ_READ: begin
								if (!pos_ok) begin
									st_q    <= alp_pkg::ST_NOPOS;
									state_q <= S_FINISH;
								end else begin
									st_q    <= alp_pkg::ST_DONE;
									state_q <= S_RD;
								end
							end
							default: begin
								st_q    <= alp_pkg::ST_DONE;
								state_q <= S_FINISH;
							end
						endcase
					end
				end
				S_OPEN: begin
					pend_s1 <= !at_lim;
					wa_s1   <= ptr[AW-1:0];
					if (!pend_s1 && at_lim) begin
						count_q <= count_q + CW'(1);
						state_q <= S_FINISH;
					end
				end
				S_RD: begin
					state_q <= S_RD2;
				end
				S_RD2: begin
					rd_q    <= mem_rdata;
					state_q <= rm_q ? S_CLOSE : S_FINISH;
				end
				S_CLOSE: begin
					pend_s1 <= !at_lim;
					wa_s1   <= ptr[AW-1:0];
					if (!pend_s1 && at_lim) begin
						count_q <= count_q - CW'(1);
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_st_q    <= st_q;
						out_rd_q    <= alp_pkg::DATA_W'(rd_q);
						out_cnt_q   <= count_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_st_q;
	assign read_value    = out_rd_q;
	assign element_count = alp_pkg::COUNT_W'(out_cnt_q);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count exceeds capacity");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("ready stayed high after an accepted item");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == $past(count_q)) || (count_q == $past(count_q) + CW'(1)) ||
		(count_q == $past(count_q) - CW'(1)))
		else $error("element count moved by more than one");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (CW'(mem_waddr) <= count_q))
		else $error("write beyond the end of the list");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_st_q == alp_pkg::ST_FULL)) |-> (out_cnt_q == CW'(CAPACITY)))
		else $error("full status reported on a list that is not full");
`endif

endmodule

### tb/tb_array_list_positional_insert_remove_core.sv
// Self-checking testbench for the bounded array list core: directed and random
// requests, with a mirror of the list that predicts every result.
// Depends on alp_pkg and array_list_positional_insert_remove_core.
`timescale 1ns / 1ps

module tb_array_list_positional_insert_remove_core;

	localparam int LIST_CAP = alp_pkg::CAPACITY_DEF;
	localparam int N_RANDOM = 1100;
	localparam int SETTLE_CYCLES = alp_pkg::CAPACITY_DEF + 8;
	// Request codes that the block treats as no operation.
	localparam logic [alp_pkg::REQ_W-1:0] REQ_SPARE_LO = 3'd5;
	localparam logic [alp_pkg::REQ_W-1:0] REQ_SPARE_HI = 3'd7;

	typedef struct {
		logic        [alp_pkg::STATUS_W-1:0] status;
		logic signed [alp_pkg::DATA_W-1:0]   data;
		logic        [alp_pkg::COUNT_W-1:0]  count;
	} list_result_t;

	typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} req_mix_t;
	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_t;

	// Mirror of the list contents and the queue of results it predicts.
	class list_mirror;
		logic signed [alp_pkg::DATA_W-1:0] elems [LIST_CAP];
		int unsigned n_elems;
		list_result_t pending_results[$];
		int unsigned errors;

		function new();
			n_elems = 0;
			errors = 0;
		endfunction

		function void apply_request(logic [alp_pkg::REQ_W-1:0] rq,
				logic [alp_pkg::POS_W-1:0] ps, logic signed [alp_pkg::DATA_W-1:0] vl);
			list_result_t r;
			int unsigned at;
			r.status = alp_pkg::ST_DONE;
			r.data = '0;
			case (rq)
				alp_pkg::REQ_APPEND: begin
					if (n_elems >= LIST_CAP) begin
						r.status = alp_pkg::ST_FULL;
					end else begin
						elems[n_elems] = vl;
						n_elems++;
					end
				end
				alp_pkg::REQ_INS_AT, alp_pkg::REQ_INS_AFTER: begin
					// The position is checked before fullness.
					if (ps >= n_elems) begin
						r.status = alp_pkg::ST_NOPOS;
					end else if (n_elems >= LIST_CAP) begin
						r.status = alp_pkg::ST_FULL;
					end else begin
						at = (rq == alp_pkg::REQ_INS_AT) ? ps : ps + 1;
						for (int j = n_elems; j > at; j--)
							elems[j] = elems[j-1];
						elems[at] = vl;
						n_elems++;
					end
				end
				alp_pkg::REQ_REMOVE: begin
					if (ps >= n_elems) begin
						r.status = alp_pkg::ST_NOPOS;
					end else begin
						r.data = elems[ps];
						for (int j = ps; j + 1 < n_elems; j++)
							elems[j] = elems[j+1];
						n_elems--;
					end
				end
				alp_pkg::REQ_READ: begin
					if (ps >= n_elems)
						r.status = alp_pkg::ST_NOPOS;
					else
						r.data = elems[ps];
				end
				default: begin
				end
			endcase
			r.count = alp_pkg::COUNT_W'(n_elems);
			pending_results.push_back(r);
		endfunction

		function void flag(string what, longint exp_v, longint got_v);
			errors++;
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, what, exp_v, got_v);
		endfunction

		function void check_result(logic [alp_pkg::STATUS_W-1:0] st,
				logic signed [alp_pkg::DATA_W-1:0] rd, logic [alp_pkg::COUNT_W-1:0] cnt);
			list_result_t e;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: status %0d, value %0d, count %0d",
					$time, st, rd, cnt);
				return;
			end
			e = pending_results.pop_front();
			if (st !== e.status)
				flag("status", e.status, st);
			if (rd !== e.data)
				flag("read_value", e.data, rd);
			if (cnt !== e.count)
				flag("element_count", e.count, cnt);
		endfunction

		function int unsigned finish_check();
			if (pending_results.size() != 0) begin
				errors += pending_results.size();
				$display("%0t: %0d expected results never arrived", $time,
					pending_results.size());
			end
			return errors;
		endfunction
	endclass

	logic                                clk;
	logic                                arst_n;
	logic                                in_valid;
	logic                                in_ready;
	logic        [alp_pkg::REQ_W-1:0]    req_type;
	logic        [alp_pkg::POS_W-1:0]    position;
	logic signed [alp_pkg::DATA_W-1:0]   value;
	logic                                out_valid;
	logic                                out_ready;
	logic        [alp_pkg::STATUS_W-1:0] status;
	logic signed [alp_pkg::DATA_W-1:0]   read_value;
	logic        [alp_pkg::COUNT_W-1:0]  element_count;

	list_mirror mirror = new();
	int unsigned burst_left;
	bit gapless;
	int unsigned rx_cycle;
	rx_mode_t rx_mode;

	array_list_positional_insert_remove_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.position     (position),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.read_value   (read_value),
		.element_count(element_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("** array_list_positional_insert_remove_core: FAILED **");
		$finish;
	end

	// Picks one of the unused request codes.
	function automatic logic [alp_pkg::REQ_W-1:0] REQ_REQ_W_SPARE();
		return alp_pkg::REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
	endfunction

	// Offers one item in the current burst, opening a gap of random length, possibly none, when the burst is used up.
	// The mirror is updated here, at the edge that accepts the item.
	task automatic offer(input logic [alp_pkg::REQ_W-1:0] rq,
			input logic [alp_pkg::POS_W-1:0] ps, input logic signed [alp_pkg::DATA_W-1:0] vl);
		int unsigned idle;
		if (burst_left == 0) begin
			idle = gapless ? 0 : $urandom_range(0, 6);
			if (idle != 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (idle - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= rq;
		position <= ps;
		value <= vl;
		do @(posedge clk); while (!in_ready);
		mirror.apply_request(rq, ps, vl);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			mirror.check_result(status, read_value, element_count);
	end

	// Receiver: switches at random between stall patterns, with a long hold-off
	// now and then so that the block backs up into its input.
	initial begin
		out_ready = 1'b0;
		rx_cycle = 0;
		rx_mode = RX_OPEN;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (rx_cycle % 128 == 0)
				rx_mode = rx_mode_t'($urandom_range(0, 3));
			if (rx_cycle % 8000 >= 2500 && rx_cycle % 8000 < 2900) begin
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_OPEN:   out_ready <= 1'b1;
					RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default:   out_ready <= (rx_cycle % 5 != 0);
				endcase
			end
		end
	end

	initial begin
		req_mix_t mix;
		int unsigned roll;
		logic [alp_pkg::REQ_W-1:0] rq;
		logic [alp_pkg::POS_W-1:0] ps;
		logic signed [alp_pkg::DATA_W-1:0] vl;
		int unsigned guard;

		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = alp_pkg::REQ_APPEND;
		position = '0;
		value = '0;
		burst_left = 0;
		gapless = 1'b0;
		mix = MIX_GROW;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// An empty list rejects every position.
		offer(alp_pkg::REQ_READ, 4'd0, 32'sd7);
		offer(alp_pkg::REQ_REMOVE, 4'd15, 32'sd0);
		offer(alp_pkg::REQ_INS_AT, 4'd0, 32'sh1234);
		offer(alp_pkg::REQ_INS_AFTER, 4'd0, 32'sh5678);
		offer(alp_pkg::REQ_APPEND, 4'd15, 32'sh7FFF_FFFF);
		offer(alp_pkg::REQ_APPEND, 4'd0, 32'sh8000_0000);
		offer(alp_pkg::REQ_INS_AT, 4'd0, -32'sd1);
		offer(alp_pkg::REQ_INS_AFTER, 4'd2, 32'sd0);
		offer(alp_pkg::REQ_READ, 4'd3, 32'sd0);
		offer(alp_pkg::REQ_READ, 4'd4, 32'sd0);
		for (int k = 0; mirror.n_elems < LIST_CAP; k++) begin
			if (k[0])
				offer(alp_pkg::REQ_APPEND, 4'($urandom), $urandom);
			else
				offer(alp_pkg::REQ_INS_AT, 4'($urandom_range(0, mirror.n_elems - 1)),
					$urandom);
		end
		offer(alp_pkg::REQ_APPEND, 4'd0, 32'sd1);
		offer(alp_pkg::REQ_INS_AT, 4'd0, 32'sd2);
		offer(alp_pkg::REQ_INS_AFTER, 4'd15, 32'sd3);
		offer(alp_pkg::REQ_READ, 4'd15, 32'sd0);
		offer(alp_pkg::REQ_REMOVE, 4'd0, 32'sd0);
		offer(alp_pkg::REQ_REMOVE, 4'd14, 32'sd0);
		offer(REQ_SPARE_LO, 4'd15, -32'sd1);
		offer(REQ_SPARE_HI, 4'd15, -32'sd1);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 64 == 0) begin
				mix = req_mix_t'($urandom_range(0, 2));
				gapless = ($urandom_range(0, 3) == 0);
			end
			roll = $urandom_range(0, 99);
			case (mix)
				MIX_GROW:
					rq = roll < 30 ? alp_pkg::REQ_APPEND : roll < 55 ? alp_pkg::REQ_INS_AT :
						roll < 80 ? alp_pkg::REQ_INS_AFTER : roll < 88 ? alp_pkg::REQ_READ :
						roll < 95 ? alp_pkg::REQ_REMOVE : REQ_SPARE_LO;
				MIX_SHRINK:
					rq = roll < 10 ? alp_pkg::REQ_APPEND : roll < 18 ? alp_pkg::REQ_INS_AT :
						roll < 26 ? alp_pkg::REQ_INS_AFTER : roll < 46 ? alp_pkg::REQ_READ :
						roll < 95 ? alp_pkg::REQ_REMOVE : REQ_SPARE_LO;
				default:
					rq = roll < 20 ? alp_pkg::REQ_APPEND : roll < 35 ? alp_pkg::REQ_INS_AT :
						roll < 50 ? alp_pkg::REQ_INS_AFTER : roll < 70 ? alp_pkg::REQ_READ :
						roll < 95 ? alp_pkg::REQ_REMOVE : REQ_SPARE_LO;
			endcase
			if (rq == REQ_SPARE_LO)
				rq = REQ_REQ_W_SPARE();

			// Mostly positions inside the list, some right at its end, some anywhere.
			roll = $urandom_range(0, 99);
			if (mirror.n_elems != 0 && roll < 80)
				ps = 4'($urandom_range(0, mirror.n_elems - 1));
			else if (roll < 90 && mirror.n_elems < LIST_CAP)
				ps = 4'(mirror.n_elems);
			else
				ps = 4'($urandom_range(0, 15));

			case ($urandom_range(0, 19))
				0:       vl = 32'sh8000_0000;
				1:       vl = 32'sh7FFF_FFFF;
				2:       vl = 32'sd0;
				3:       vl = -32'sd1;
				default: vl = $urandom;
			endcase
			offer(rq, ps, vl);
		end
		@(negedge clk);
		in_valid <= 1'b0;

		guard = 0;
		while (mirror.pending_results.size() != 0 && guard < 50000) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mirror.finish_check() == 0)
			$display("** array_list_positional_insert_remove_core: PASSED **");
		else
			$display("** array_list_positional_insert_remove_core: FAILED **");
		$finish;
	end

endmodule
